// ----- rtl/grg_pkg.sv -----
// Gamma ramp generator: shared types, register indexes and constants.
// Holds the elaboration-time root table used by the exp2 cells.
// No dependencies.
package grg_pkg;

	typedef logic [2:0] reg_idx_t;

	localparam reg_idx_t REG_RAMP_ENTRIES  = 3'd0;
	localparam reg_idx_t REG_RED_WEIGHT    = 3'd1;
	localparam reg_idx_t REG_GREEN_WEIGHT  = 3'd2;
	localparam reg_idx_t REG_BLUE_WEIGHT   = 3'd3;
	localparam reg_idx_t REG_INVERSE_GAMMA = 3'd4;

	localparam logic [12:0] RAMP_RESET   = 13'd256;
	localparam logic [15:0] WEIGHT_RESET = 16'd32768;
	localparam logic [15:0] IGAMMA_RESET = 16'd4096;

	localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
	localparam logic [15:0] FULL_SCALE = 16'hFFFF;

	// tag carried through the log2 cells
	typedef struct packed {
		logic       zero;
		logic [4:0] msb;
	} log_tag_t;

	// tag carried through the exp2 cells
	typedef struct packed {
		logic       zero;
		logic       hi;
		logic       under;
		logic [5:0] sh;
	} exp_tag_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
		logic [63:0] x;
		logic [63:0] res;
		logic [63:0] bitv;
		x    = x_in;
		res  = 64'd0;
		bitv = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (x >= res + bitv) begin
				x   = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// 2^(2^-k) in Q1.30, by repeated integer square root
	function automatic logic [30:0] exp_root(input int unsigned k);
		logic [63:0] c;
		c = 64'd1 << 31;
		for (int unsigned j = 1; j <= k; j++) begin
			c = isqrt64(c << 30);
		end
		return c[30:0];
	endfunction

endpackage

// ----- rtl/gamma_ramp_generator_unit.sv -----
// Gamma ramp generator top level: config registers, 56-stage cell pipeline.
// Depends on grg_pkg, grg_div_cell, grg_log_cell, grg_exp_cell.
//
//   channel   valid          stall          payload
//   entry     entry_valid    entry_stall    entry_index
//   result    result_valid   result_stall   red/green/blue_value, clipped
//
// One item per cycle while no result is held; the pipeline holds 17 shared
// division cells, then 16 log2 cells and 16 exp2 cells per channel, plus
// input, base, normalise, product, split, scale and output stages.
// Reset clears config to defaults and empties the pipeline; no clearing pass.
// A held result freezes the whole pipeline; entry_stall follows it.
module gamma_ramp_generator_unit #(
	parameter int unsigned MAX_RAMP_ENTRIES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        entry_valid,
	output logic        entry_stall,
	input  logic [11:0] entry_index,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [15:0] red_value,
	output logic [15:0] green_value,
	output logic [15:0] blue_value,
	output logic        clipped,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam logic [12:0] N_CAP =
		(MAX_RAMP_ENTRIES > 8191) ? 13'd8191 : 13'(MAX_RAMP_ENTRIES);
	localparam int unsigned STAGES = 56;

	logic [12:0] ramp_entries_q;
	logic [15:0] weight_q [3];
	logic [15:0] inv_gamma_q;

	logic [STAGES-1:0] vld_q;
	logic              en;

	logic [12:0] n_eff;
	logic [12:0] div_d;
	logic [12:0] idx_cl;
	logic [12:0] idx_s1;

	logic [12:0] div_r [17];
	logic [16:0] div_q [17];

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_entries_q <= grg_pkg::RAMP_RESET;
			weight_q[0]    <= grg_pkg::WEIGHT_RESET;
			weight_q[1]    <= grg_pkg::WEIGHT_RESET;
			weight_q[2]    <= grg_pkg::WEIGHT_RESET;
			inv_gamma_q    <= grg_pkg::IGAMMA_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				grg_pkg::REG_RAMP_ENTRIES:  ramp_entries_q <= cfg_data[12:0];
				grg_pkg::REG_RED_WEIGHT:    weight_q[0]    <= cfg_data;
				grg_pkg::REG_GREEN_WEIGHT:  weight_q[1]    <= cfg_data;
				grg_pkg::REG_BLUE_WEIGHT:   weight_q[2]    <= cfg_data;
				grg_pkg::REG_INVERSE_GAMMA: inv_gamma_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en           = !(result_valid && result_stall);
	assign entry_stall  = !en;
	assign result_valid = vld_q[STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[STAGES-2:0], entry_valid};
		end
	end

	always_comb begin
		n_eff = ramp_entries_q;
		if (ramp_entries_q < 13'd2) begin
			n_eff = 13'd2;
		end else if (ramp_entries_q > N_CAP) begin
			n_eff = N_CAP;
		end
		div_d  = n_eff - 13'd1;
		idx_cl = ({1'b0, entry_index} > div_d) ? div_d : {1'b0, entry_index};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1 <= idx_cl;
		end
	end

	// position e = idx * 2^16 / (n-1)
	for (genvar k = 0; k < 17; k++) begin : g_div
		if (k == 0) begin : g_first
			grg_div_cell u_cell (
				.clk     (clk),
				.en      (en),
				.d       (div_d),
				.rem_in  ({1'b0, idx_s1}),
				.q_in    (17'd0),
				.rem_out (div_r[k]),
				.q_out   (div_q[k])
			);
		end else begin : g_next
			grg_div_cell u_cell (
				.clk     (clk),
				.en      (en),
				.d       (div_d),
				.rem_in  ({div_r[k-1], 1'b0}),
				.q_in    (div_q[k-1]),
				.rem_out (div_r[k]),
				.q_out   (div_q[k])
			);
		end
	end

	logic [15:0] ch_val [3];
	logic        ch_clip [3];

	for (genvar c = 0; c < 3; c++) begin : g_ch
		logic [32:0]        bprod;
		logic [16:0]        base_s19;
		logic [4:0]         msb;
		logic [47:0]        nshift;
		logic [30:0]        norm_m_s20;
		grg_pkg::log_tag_t  norm_t_s20;
		logic [30:0]        log_m [1:16];
		logic [15:0]        log_f [1:16];
		grg_pkg::log_tag_t  log_t [1:16];
		logic [5:0]         intp;
		logic signed [21:0] lg;
		logic signed [38:0] prod;
		logic signed [38:0] prod_s37;
		logic               zero_s37;
		logic signed [38:0] prnd;
		logic [26:0]        y;
		logic signed [10:0] ip;
		logic [10:0]        ip_neg;
		logic [15:0]        fp_s38;
		grg_pkg::exp_tag_t  et_s38;
		logic [30:0]        exp_m [1:16];
		logic [15:0]        exp_f [1:16];
		grg_pkg::exp_tag_t  exp_t [1:16];
		logic [46:0]        vm_s55;
		grg_pkg::exp_tag_t  vt_s55;
		logic [46:0]        shv;

		assign bprod = 33'(div_q[16]) * 33'(weight_q[c]);

		always_ff @(posedge clk) begin
			if (en) begin
				base_s19 <= bprod[31:15];
			end
		end

		always_comb begin
			msb = 5'd0;
			for (int j = 0; j < 17; j++) begin
				if (base_s19[j]) begin
					msb = 5'(j);
				end
			end
			nshift = {31'd0, base_s19} << (5'd30 - msb);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				norm_m_s20      <= nshift[30:0];
				norm_t_s20.zero <= base_s19 == 17'd0;
				norm_t_s20.msb  <= msb;
			end
		end

		for (genvar k = 1; k <= 16; k++) begin : g_log
			if (k == 1) begin : g_first
				grg_log_cell #(.K(k), .TAG_W($bits(grg_pkg::log_tag_t))) u_cell (
					.clk      (clk),
					.en       (en),
					.m_in     (norm_m_s20),
					.frac_in  (16'd0),
					.tag_in   (norm_t_s20),
					.m_out    (log_m[k]),
					.frac_out (log_f[k]),
					.tag_out  (log_t[k])
				);
			end else begin : g_next
				grg_log_cell #(.K(k), .TAG_W($bits(grg_pkg::log_tag_t))) u_cell (
					.clk      (clk),
					.en       (en),
					.m_in     (log_m[k-1]),
					.frac_in  (log_f[k-1]),
					.tag_in   (log_t[k-1]),
					.m_out    (log_m[k]),
					.frac_out (log_f[k]),
					.tag_out  (log_t[k])
				);
			end
		end

		// L = (msb-16).frac, times inverse gamma
		assign intp = {1'b0, log_t[16].msb} - 6'd16;
		assign lg   = $signed({intp, log_f[16]});
		assign prod = 39'($signed({1'b0, inv_gamma_q})) * 39'(lg);

		always_ff @(posedge clk) begin
			if (en) begin
				prod_s37 <= prod;
				zero_s37 <= log_t[16].zero;
			end
		end

		// truncate toward zero, split into integer and fraction
		assign prnd   = prod_s37 + (prod_s37[38] ? 39'sd4095 : 39'sd0);
		assign y      = prnd[38:12];
		assign ip     = $signed(y[26:16]);
		assign ip_neg = 11'd0 - y[26:16];

		always_ff @(posedge clk) begin
			if (en) begin
				fp_s38       <= y[15:0];
				et_s38.zero  <= zero_s37;
				et_s38.hi    <= !ip[10] && (ip != 11'sd0);
				et_s38.under <= ip < -11'sd33;
				et_s38.sh    <= ip_neg[5:0];
			end
		end

		for (genvar k = 1; k <= 16; k++) begin : g_exp
			if (k == 1) begin : g_first
				grg_exp_cell #(.K(k), .TAG_W($bits(grg_pkg::exp_tag_t))) u_cell (
					.clk     (clk),
					.en      (en),
					.m_in    (grg_pkg::ONE_Q30),
					.fp_in   (fp_s38),
					.tag_in  (et_s38),
					.m_out   (exp_m[k]),
					.fp_out  (exp_f[k]),
					.tag_out (exp_t[k])
				);
			end else begin : g_next
				grg_exp_cell #(.K(k), .TAG_W($bits(grg_pkg::exp_tag_t))) u_cell (
					.clk     (clk),
					.en      (en),
					.m_in    (exp_m[k-1]),
					.fp_in   (exp_f[k-1]),
					.tag_in  (exp_t[k-1]),
					.m_out   (exp_m[k]),
					.fp_out  (exp_f[k]),
					.tag_out (exp_t[k])
				);
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				vm_s55 <= 47'(grg_pkg::FULL_SCALE) * 47'(exp_m[16]);
				vt_s55 <= exp_t[16];
			end
		end

		assign shv = vm_s55 >> (6'd30 + vt_s55.sh);

		always_comb begin
			ch_val[c]  = shv[15:0];
			ch_clip[c] = 1'b0;
			if (vt_s55.zero || vt_s55.under) begin
				ch_val[c] = 16'd0;
			end else if (vt_s55.hi || (shv > 47'(grg_pkg::FULL_SCALE))) begin
				ch_val[c]  = grg_pkg::FULL_SCALE;
				ch_clip[c] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_value   <= ch_val[0];
			green_value <= ch_val[1];
			blue_value  <= ch_val[2];
			clipped     <= ch_clip[0] || ch_clip[1] || ch_clip[2];
		end
	end

`ifndef SYNTH
	a_clip_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && clipped |->
			(red_value == grg_pkg::FULL_SCALE) || (green_value == grg_pkg::FULL_SCALE) ||
			(blue_value == grg_pkg::FULL_SCALE))
		else $error("clip flag without a saturated channel");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		entry_stall |-> result_valid && result_stall)
		else $error("entry stalled with no held result");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		entry_stall |=> $stable(vld_q))
		else $error("pipeline moved while frozen");
`endif

endmodule

// ----- rtl/grg_div_cell.sv -----
// Gamma ramp generator: one restoring-division cell, one quotient bit.
// Uses no package items.
module grg_div_cell (
	input  logic        clk,
	input  logic        en,
	input  logic [12:0] d,
	input  logic [13:0] rem_in,
	input  logic [16:0] q_in,
	output logic [12:0] rem_out,
	output logic [16:0] q_out
);

	logic        ge;
	logic [13:0] diff;

	assign ge   = rem_in >= {1'b0, d};
	assign diff = rem_in - {1'b0, d};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out <= ge ? diff[12:0] : rem_in[12:0];
			q_out   <= {q_in[15:0], ge};
		end
	end

endmodule

// ----- rtl/grg_log_cell.sv -----
// Gamma ramp generator: one log2 fraction cell (square, renormalise, bit).
// Uses no package items.
module grg_log_cell #(
	parameter int unsigned K     = 1,
	parameter int unsigned TAG_W = 6
) (
	input  logic             clk,
	input  logic             en,
	input  logic [30:0]      m_in,
	input  logic [15:0]      frac_in,
	input  logic [TAG_W-1:0] tag_in,
	output logic [30:0]      m_out,
	output logic [15:0]      frac_out,
	output logic [TAG_W-1:0] tag_out
);

	localparam logic [15:0] FBIT = 16'(1) << (16 - K);

	logic [61:0] sq;
	logic [31:0] s;

	assign sq = 62'(m_in) * 62'(m_in);
	assign s  = sq[61:30];

	always_ff @(posedge clk) begin
		if (en) begin
			m_out    <= s[31] ? s[31:1] : s[30:0];
			frac_out <= s[31] ? (frac_in | FBIT) : frac_in;
			tag_out  <= tag_in;
		end
	end

endmodule

// ----- rtl/grg_exp_cell.sv -----
// Gamma ramp generator: one exp2 cell, multiplies by a fixed root if its bit is set.
// Depends on grg_pkg (exp_root).
module grg_exp_cell #(
	parameter int unsigned K     = 1,
	parameter int unsigned TAG_W = 9
) (
	input  logic             clk,
	input  logic             en,
	input  logic [30:0]      m_in,
	input  logic [15:0]      fp_in,
	input  logic [TAG_W-1:0] tag_in,
	output logic [30:0]      m_out,
	output logic [15:0]      fp_out,
	output logic [TAG_W-1:0] tag_out
);

	localparam logic [30:0] ROOT = grg_pkg::exp_root(K);
	localparam int unsigned BIT  = 16 - K;

	logic [61:0] prod;

	assign prod = 62'(m_in) * 62'(ROOT);

	always_ff @(posedge clk) begin
		if (en) begin
			m_out   <= fp_in[BIT] ? prod[60:30] : m_in;
			fp_out  <= fp_in;
			tag_out <= tag_in;
		end
	end

endmodule

// ----- test/gamma_ramp_generator_unit_tb.sv -----
// Testbench for gamma_ramp_generator_unit: random and directed ramp indexes under
// several register settings, with an in-bench fixed-point gamma predictor and a scoreboard.
// Depends on grg_pkg and the RTL top level.
`timescale 1ns / 1ps

module gamma_ramp_generator_unit_tb;

	localparam int MAX_ENTRIES = 4096;
	localparam int LIMIT_CYCLES = 400000;
	localparam logic [2:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic        clip;
	} ramp_entry_t;

	logic        clk;
	logic        arst_n;
	logic        entry_valid = 1'b0;
	logic        entry_stall;
	logic [11:0] entry_index = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [15:0] red_value;
	logic [15:0] green_value;
	logic [15:0] blue_value;
	logic        clipped;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	logic [12:0] ramp_n;
	logic [15:0] weight_r, weight_g, weight_b, igamma;
	logic [63:0] roots [17];

	logic [11:0]  index_queue [$];
	ramp_entry_t  expected_entries [$];
	int  errors = 0;
	int  cycles = 0;
	bit  sender_hold;
	bit  entry_taken = 1'b0;
	int  hold_off_req = 0;
	int  hold_off_left = 0;
	bit  hold_off_done = 1'b0;
	int  burst_left = 0;
	int  gap_left = 0;

	gamma_ramp_generator_unit DUT (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] int_sqrt(input logic [63:0] x_in);
		logic [63:0] x, res, b;
		x = x_in;
		res = 0;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint log2_fixed(input logic [63:0] b);
		int msb;
		logic [63:0] m;
		longint frac;
		msb = 0;
		frac = 0;
		while (msb < 63 && (b >> (msb + 1)) != 0)
			msb++;
		m = (msb <= 30) ? (b << (30 - msb)) : (b >> (msb - 30));
		for (int k = 1; k <= 16; k++) begin
			m = (m * m) >> 30;
			if (m >= (64'd2 << 30)) begin
				m = m >> 1;
				frac = frac | (longint'(1) << (16 - k));
			end
		end
		return longint'(msb - 16) * 65536 + frac;
	endfunction

	function automatic logic [15:0] channel_value(input logic [63:0] e,
			input logic [15:0] w, inout logic clip);
		logic [63:0] b, m, v;
		longint y, ip, fp;
		int sh;
		b = (e * w) >> 15;
		if (b == 0)
			return 16'd0;
		y = (longint'(igamma) * log2_fixed(b)) / 4096;
		if (y >= 0)
			ip = y / 65536;
		else
			ip = -((-y + 65535) / 65536);
		fp = y - ip * 65536;
		if (ip >= 1) begin
			clip = 1'b1;
			return grg_pkg::FULL_SCALE;
		end
		m = 64'd1 << 30;
		for (int k = 1; k <= 16; k++)
			if ((fp >> (16 - k)) & 1)
				m = (m * roots[k]) >> 30;
		v = 64'd65535 * m;
		sh = 30 - int'(ip);
		if (sh >= 64)
			return 16'd0;
		v = v >> sh;
		if (v > 65535) begin
			clip = 1'b1;
			return grg_pkg::FULL_SCALE;
		end
		return v[15:0];
	endfunction

	function automatic ramp_entry_t predict_entry(input logic [11:0] idx_in);
		ramp_entry_t r;
		logic [63:0] n, idx, e;
		logic clip;
		n = ramp_n;
		if (n < 2)
			n = 2;
		if (n > MAX_ENTRIES)
			n = MAX_ENTRIES;
		idx = idx_in;
		if (idx > n - 1)
			idx = n - 1;
		e = (idx << 16) / (n - 1);
		clip = 1'b0;
		r.red = channel_value(e, weight_r, clip);
		r.green = channel_value(e, weight_g, clip);
		r.blue = channel_value(e, weight_b, clip);
		r.clip = clip;
		return r;
	endfunction

	task automatic queue_index(input logic [11:0] v);
		index_queue = {index_queue, v};
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			grg_pkg::REG_RAMP_ENTRIES:  ramp_n = val[12:0];
			grg_pkg::REG_RED_WEIGHT:    weight_r = val;
			grg_pkg::REG_GREEN_WEIGHT:  weight_g = val;
			grg_pkg::REG_BLUE_WEIGHT:   weight_b = val;
			grg_pkg::REG_INVERSE_GAMMA: igamma = val;
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (index_queue.size() != 0 || expected_entries.size() != 0)
			@(negedge clk);
		repeat (64) @(negedge clk);
	endtask

	// driver: bursts and gaps, payload held until taken
	always @(negedge clk) begin
		if (!arst_n) begin
			entry_valid <= 1'b0;
		end else if (!entry_valid || entry_taken) begin
			if (burst_left == 0 && gap_left == 0) begin
				burst_left = $urandom_range(1, 40);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			end
			if (!sender_hold && index_queue.size() != 0 && (gap_left == 0)) begin
				entry_valid <= 1'b1;
				entry_index <= index_queue[0];
				if (burst_left > 0)
					burst_left--;
			end else begin
				entry_valid <= 1'b0;
				entry_index <= 12'($urandom);
				if (gap_left > 0)
					gap_left--;
			end
		end
	end

	// receiver stall pattern, with one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_off_req != 0 && !hold_off_done) begin
				hold_off_left = hold_off_req;
				hold_off_done = 1'b1;
			end
			if (hold_off_left > 0) begin
				hold_off_left--;
				result_stall <= 1'b1;
			end else if (cycles % 600 < 200) begin
				result_stall <= 1'b0;
			end else begin
				result_stall <= ($urandom_range(0, 2) == 0);
			end
		end
	end

	// monitor and scoreboard
	always @(posedge clk) begin
		ramp_entry_t exp_e;
		if (arst_n) begin
			cycles <= cycles + 1;
			entry_taken = entry_valid && !entry_stall;
			if (entry_valid && !entry_stall) begin
				expected_entries = {expected_entries, predict_entry(entry_index)};
				void'(index_queue.pop_front());
			end
			if (result_valid && !result_stall) begin
				if (expected_entries.size() == 0) begin
					$error("result with no expectation waiting");
					errors++;
				end else begin
					exp_e = expected_entries.pop_front();
					if (red_value !== exp_e.red) begin
						$error("red_value expected %0d actual %0d", exp_e.red, red_value);
						errors++;
					end
					if (green_value !== exp_e.green) begin
						$error("green_value expected %0d actual %0d", exp_e.green,
							green_value);
						errors++;
					end
					if (blue_value !== exp_e.blue) begin
						$error("blue_value expected %0d actual %0d", exp_e.blue, blue_value);
						errors++;
					end
					if (clipped !== exp_e.clip) begin
						$error("clipped expected %0d actual %0d", exp_e.clip, clipped);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		wait (cycles >= LIMIT_CYCLES);
		$display("TEST FAILED");
		$finish;
	end

	task automatic random_phase(input int count);
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 3))
				0: queue_index(12'($urandom));
				1: queue_index(12'($urandom_range(0, 15)));
				2: queue_index(12'(ramp_n - 1 - $urandom_range(0, 3)));
				default: queue_index(12'($urandom_range(0, ramp_n)));
			endcase
		end
	endtask

	initial begin
		logic [15:0] wset [6];
		logic [15:0] gset [6];
		logic [15:0] nset [6];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sender_hold = 1'b0;
		ramp_n = grg_pkg::RAMP_RESET;
		weight_r = grg_pkg::WEIGHT_RESET;
		weight_g = grg_pkg::WEIGHT_RESET;
		weight_b = grg_pkg::WEIGHT_RESET;
		igamma = grg_pkg::IGAMMA_RESET;
		roots[0] = 64'd2 << 30;
		for (int k = 1; k <= 16; k++)
			roots[k] = int_sqrt(roots[k - 1] << 30);
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset settings, index extremes and clamping
		queue_index(12'd0);
		queue_index(12'd1);
		queue_index(12'd128);
		queue_index(12'd255);
		queue_index(12'd256);
		queue_index(12'hFFF);
		queue_index(12'hAAA);
		queue_index(12'h555);
		wait_drained();
		// zero weight, above-one weight, zero exponent, tiny ramp
		write_reg(grg_pkg::REG_RED_WEIGHT, 16'd0);
		write_reg(grg_pkg::REG_GREEN_WEIGHT, 16'hFFFF);
		write_reg(grg_pkg::REG_BLUE_WEIGHT, 16'd1);
		write_reg(grg_pkg::REG_INVERSE_GAMMA, 16'd0);
		write_reg(grg_pkg::REG_RAMP_ENTRIES, 16'd0);
		queue_index(12'd0);
		queue_index(12'd1);
		queue_index(12'hFFF);
		wait_drained();
		write_reg(grg_pkg::REG_INVERSE_GAMMA, 16'hFFFF);
		write_reg(grg_pkg::REG_RAMP_ENTRIES, 16'h1FFF);
		queue_index(12'd1);
		queue_index(12'd2048);
		queue_index(12'hFFF);
		queue_index(12'hFFE);
		wait_drained();
		write_reg(grg_pkg::REG_INVERSE_GAMMA, 16'd1);
		write_reg(grg_pkg::REG_RAMP_ENTRIES, 16'd4096);
		write_reg(REG_UNUSED, 16'h1234);
		queue_index(12'd1);
		queue_index(12'hFFF);
		queue_index(12'd7);
		wait_drained();

		wset = '{16'd0, 16'd1, 16'd16384, 16'd32768, 16'd40000, 16'hFFFF};
		gset = '{16'd1, 16'd4096, 16'd9011, 16'd1862, 16'd20000, 16'hFFFF};
		nset = '{16'd2, 16'd3, 16'd256, 16'd1000, 16'd4096, 16'd5000};
		for (int p = 0; p < 8; p++) begin
			write_reg(grg_pkg::REG_RAMP_ENTRIES,
				(p < 6) ? nset[p] : 16'($urandom_range(2, 4096)));
			write_reg(grg_pkg::REG_RED_WEIGHT,
				wset[$urandom_range(0, 5)] ^ (p[0] ? 16'($urandom) : 16'd0));
			write_reg(grg_pkg::REG_GREEN_WEIGHT, wset[$urandom_range(0, 5)]);
			write_reg(grg_pkg::REG_BLUE_WEIGHT, 16'($urandom));
			write_reg(grg_pkg::REG_INVERSE_GAMMA, (p < 6) ? gset[p] : 16'($urandom));
			random_phase(160);
			if (p == 2) begin
				hold_off_req = 300;
				random_phase(20);
			end
			if (p == 4) begin
				while (index_queue.size() > 60)
					@(negedge clk);
				sender_hold = 1'b1;
				while (expected_entries.size() != 0)
					@(negedge clk);
				sender_hold = 1'b0;
			end
			wait_drained();
		end

		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
